// ===== hw/rtl/bresenham_two_motor_stepper_assert.svh =====
// ----------------------------------------------------------------------------
// stepper assertion macros
// shared assertion forms for the stepper checkers
// ----------------------------------------------------------------------------
`ifndef BRESENHAM_TWO_MOTOR_STEPPER_ASSERT_SVH
`define BRESENHAM_TWO_MOTOR_STEPPER_ASSERT_SVH

// same-cycle implication
`define BTMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper check failed");

// next-cycle implication
`define BTMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper check failed");

`endif

// ===== hw/rtl/btms_pkg.sv =====
// ----------------------------------------------------------------------------
// btms_pkg
// shared types and constants of the two-motor line stepper
// ----------------------------------------------------------------------------
package btms_pkg;

    localparam int COORD_BITS_DEFAULT = 14;
    localparam int POS_BITS           = 18;
    localparam int SPAN_BITS          = 19;
    localparam int ERR_BITS           = 20;
    localparam int SPU_BITS           = 4;
    localparam logic [SPU_BITS-1:0] SPU_RESET = 4'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic FUNC_MOVE = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    typedef struct packed {
        logic step_pulse;
        logic motor1_cw;
        logic motor2_cw;
        logic last_of_run;
        logic move_done;
        logic rejected;
    } btms_res_t;

    typedef struct packed {
        logic                       valid;
        logic                       func;
        logic signed [POS_BITS-1:0] tx;
        logic signed [POS_BITS-1:0] ty;
    } btms_item_t;

    typedef struct packed {
        logic      push0;
        logic      push1;
        btms_res_t row0;
        btms_res_t row1;
    } btms_push_t;

    // direction pair for one step on an axis
    function automatic btms_res_t btms_step_row(input logic on_y, input logic neg);
        btms_res_t r;
        r            = '0;
        r.step_pulse = 1'b1;
        if (on_y)
        begin
            r.motor1_cw = neg;
            r.motor2_cw = !neg;
        end
        else
        begin
            r.motor1_cw = !neg;
            r.motor2_cw = !neg;
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/bresenham_two_motor_stepper.sv =====
// ----------------------------------------------------------------------------
// bresenham_two_motor_stepper
// two-motor pen plotter line stepper, one Bresenham iteration per tick
// ----------------------------------------------------------------------------
// Usage:
// - cmd channel: func selects a move (target_x/target_y in plot units) or a
//   step tick; a request is taken when cmd_valid is high and cmd_stall low
// - res channel: step and status rows, each taken on res_valid high and
//   res_stall low; last_of_run marks the final row of an input request
// - cfg_wr_en/cfg_wr_data write steps_per_unit; write only while idle
// - a taken request is held in the input register until the core takes it
//   while the queue has room; its rows are written to the result queue and
//   are offered on res_valid from there
// - one request per cycle is taken while the result queue has room for two
//   rows; a tick that steps both axes gives two rows, and the single result
//   port drains one row a cycle when not stalled; such ticks fill the queue
// - moves and rejected moves give at most one row, 1 per cycle if unstalled
// - reset clears the pen position to the origin, leaves the block idle with
//   an empty queue and sets steps_per_unit to 2
// - while res_stall is high the head row holds; the queue fills and then
//   cmd_stall rises, so no row is lost
// ----------------------------------------------------------------------------
module bresenham_two_motor_stepper
    import btms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [SPU_BITS-1:0]          cfg_wr_data,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] target_x,
    input  logic signed [COORD_BITS-1:0] target_y,
    output logic                         res_valid,
    input  logic                         res_stall,
    output logic                         step_pulse,
    output logic                         motor1_cw,
    output logic                         motor2_cw,
    output logic                         last_of_run,
    output logic                         move_done,
    output logic                         rejected
);

    btms_item_t item;
    btms_push_t push;
    btms_res_t  head;
    logic       take;
    logic       room;

    btms_input_stage #(
        .COORD_BITS (COORD_BITS)
    ) u_input (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .func        (func),
        .target_x    (target_x),
        .target_y    (target_y),
        .take        (take),
        .item        (item)
    );

    btms_step_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .room  (room),
        .take  (take),
        .push  (push)
    );

    btms_result_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .head      (head)
    );

    assign step_pulse  = head.step_pulse;
    assign motor1_cw   = head.motor1_cw;
    assign motor2_cw   = head.motor2_cw;
    assign last_of_run = head.last_of_run;
    assign move_done   = head.move_done;
    assign rejected    = head.rejected;

endmodule

// ===== hw/rtl/btms_input_stage.sv =====
// ----------------------------------------------------------------------------
// btms_input_stage
// request register with target scaling and the steps-per-unit register
// ----------------------------------------------------------------------------
module btms_input_stage
    import btms_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEFAULT
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [SPU_BITS-1:0]          cfg_wr_data,
    input  logic                         cmd_valid,
    output logic                         cmd_stall,
    input  logic                         func,
    input  logic signed [COORD_BITS-1:0] target_x,
    input  logic signed [COORD_BITS-1:0] target_y,
    input  logic                         take,
    output btms_item_t                   item
);

    localparam int PROD_W = (COORD_BITS + SPU_BITS + 1 > POS_BITS) ?
                            (COORD_BITS + SPU_BITS + 1) : POS_BITS;

    logic [SPU_BITS-1:0]        spu_reg;
    logic                       valid_reg;
    logic                       func_reg;
    logic signed [POS_BITS-1:0] tx_reg;
    logic signed [POS_BITS-1:0] ty_reg;

    logic                     load;
    logic signed [PROD_W-1:0] spu_ext;
    logic signed [PROD_W-1:0] tx_ext;
    logic signed [PROD_W-1:0] ty_ext;
    logic signed [PROD_W-1:0] tx_prod;
    logic signed [PROD_W-1:0] ty_prod;

    assign cmd_stall = valid_reg && !take;
    assign load      = cmd_valid && !cmd_stall;

    assign spu_ext = PROD_W'({1'b0, spu_reg});
    assign tx_ext  = PROD_W'(target_x);
    assign ty_ext  = PROD_W'(target_y);
    assign tx_prod = tx_ext * spu_ext;
    assign ty_prod = ty_ext * spu_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spu_reg   <= SPU_RESET;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                spu_reg <= cfg_wr_data;
            end
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (take)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // scaled target wraps to the position width
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            func_reg <= func;
            tx_reg   <= tx_prod[POS_BITS-1:0];
            ty_reg   <= ty_prod[POS_BITS-1:0];
        end
    end

    assign item.valid = valid_reg;
    assign item.func  = func_reg;
    assign item.tx    = tx_reg;
    assign item.ty    = ty_reg;

endmodule

// ===== hw/rtl/btms_step_core.sv =====
// ----------------------------------------------------------------------------
// btms_step_core
// line set-up and one Bresenham iteration per tick, pen position tracking
// ----------------------------------------------------------------------------
module btms_step_core
    import btms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  btms_item_t item,
    input  logic       room,
    output logic       take,
    output btms_push_t push
);

    logic signed [POS_BITS-1:0]  pos_x_reg, pos_x_next;
    logic signed [POS_BITS-1:0]  pos_y_reg, pos_y_next;
    logic signed [ERR_BITS-1:0]  err_reg, err_next;
    logic [POS_BITS-1:0]         left_reg, left_next;
    logic [SPAN_BITS-1:0]        minc_reg, minc_next;
    logic [SPAN_BITS-1:0]        mspan_reg, mspan_next;
    logic                        xneg_reg, xneg_next;
    logic                        yneg_reg, yneg_next;
    logic                        ymaj_reg, ymaj_next;
    logic                        busy_reg, busy_next;

    logic signed [SPAN_BITS-1:0] dx;
    logic signed [SPAN_BITS-1:0] dy;
    logic [SPAN_BITS-1:0]        ax_w;
    logic [SPAN_BITS-1:0]        ay_w;
    logic [POS_BITS-1:0]         ax;
    logic [POS_BITS-1:0]         ay;
    logic [POS_BITS-1:0]         lo;
    logic [POS_BITS-1:0]         sh;
    logic signed [ERR_BITS-1:0]  err_add;
    logic                        minor_take;
    logic                        finish;
    logic                        x_step;
    logic                        y_step;
    btms_res_t                   row_maj;
    btms_res_t                   row_min;
    btms_res_t                   row_flag;

    assign take = item.valid && room;

    // set-up arithmetic
    assign dx   = {item.tx[POS_BITS-1], item.tx} - {pos_x_reg[POS_BITS-1], pos_x_reg};
    assign dy   = {item.ty[POS_BITS-1], item.ty} - {pos_y_reg[POS_BITS-1], pos_y_reg};
    assign ax_w = dx[SPAN_BITS-1] ? SPAN_BITS'(-dx) : SPAN_BITS'(dx);
    assign ay_w = dy[SPAN_BITS-1] ? SPAN_BITS'(-dy) : SPAN_BITS'(dy);
    assign ax   = ax_w[POS_BITS-1:0];
    assign ay   = ay_w[POS_BITS-1:0];
    assign lo   = (ax >= ay) ? ax : ay;
    assign sh   = (ax >= ay) ? ay : ax;

    // iteration arithmetic
    assign err_add    = err_reg + $signed({1'b0, minc_reg});
    assign minor_take = !err_add[ERR_BITS-1] && (err_add != '0);
    assign finish     = (left_reg == POS_BITS'(1));
    assign x_step     = !ymaj_reg || minor_take;
    assign y_step     = ymaj_reg || minor_take;

    always_comb
    begin
        row_maj = btms_step_row(ymaj_reg, ymaj_reg ? yneg_reg : xneg_reg);
        row_min = btms_step_row(!ymaj_reg, ymaj_reg ? xneg_reg : yneg_reg);
        row_flag = '0;
        row_flag.last_of_run = 1'b1;

        pos_x_next = pos_x_reg;
        pos_y_next = pos_y_reg;
        err_next   = err_reg;
        left_next  = left_reg;
        minc_next  = minc_reg;
        mspan_next = mspan_reg;
        xneg_next  = xneg_reg;
        yneg_next  = yneg_reg;
        ymaj_next  = ymaj_reg;
        busy_next  = busy_reg;
        push       = '0;

        if (take)
        begin
            if (item.func == FUNC_MOVE)
            begin
                if (busy_reg)
                begin
                    push.push0         = 1'b1;
                    push.row0          = row_flag;
                    push.row0.rejected = 1'b1;
                end
                else if (lo == '0)
                begin
                    push.push0          = 1'b1;
                    push.row0           = row_flag;
                    push.row0.move_done = 1'b1;
                end
                else
                begin
                    xneg_next  = dx[SPAN_BITS-1];
                    yneg_next  = dy[SPAN_BITS-1];
                    ymaj_next  = (ax < ay);
                    err_next   = ERR_BITS'(0) - ERR_BITS'({1'b0, lo});
                    mspan_next = {lo, 1'b0};
                    minc_next  = {sh, 1'b0};
                    left_next  = lo;
                    busy_next  = 1'b1;
                end
            end
            else if (busy_reg)
            begin
                left_next = left_reg - POS_BITS'(1);
                busy_next = !finish;
                err_next  = minor_take ? (err_add - $signed({1'b0, mspan_reg})) : err_add;
                if (x_step)
                begin
                    pos_x_next = xneg_reg ? (pos_x_reg - POS_BITS'(1))
                                          : (pos_x_reg + POS_BITS'(1));
                end
                if (y_step)
                begin
                    pos_y_next = yneg_reg ? (pos_y_reg - POS_BITS'(1))
                                          : (pos_y_reg + POS_BITS'(1));
                end
                push.push0 = 1'b1;
                push.row0  = row_maj;
                // flags go on the last row of the tick
                if (minor_take)
                begin
                    push.push1            = 1'b1;
                    push.row1             = row_min;
                    push.row1.last_of_run = 1'b1;
                    push.row1.move_done   = finish;
                end
                else
                begin
                    push.row0.last_of_run = 1'b1;
                    push.row0.move_done   = finish;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg <= '0;
            pos_y_reg <= '0;
            err_reg   <= '0;
            left_reg  <= '0;
            minc_reg  <= '0;
            mspan_reg <= '0;
            xneg_reg  <= 1'b0;
            yneg_reg  <= 1'b0;
            ymaj_reg  <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            pos_x_reg <= pos_x_next;
            pos_y_reg <= pos_y_next;
            err_reg   <= err_next;
            left_reg  <= left_next;
            minc_reg  <= minc_next;
            mspan_reg <= mspan_next;
            xneg_reg  <= xneg_next;
            yneg_reg  <= yneg_next;
            ymaj_reg  <= ymaj_next;
            busy_reg  <= busy_next;
        end
    end

endmodule

// ===== hw/rtl/btms_result_queue.sv =====
// ----------------------------------------------------------------------------
// btms_result_queue
// small result queue taking up to two rows a cycle and giving one when not stalled
// ----------------------------------------------------------------------------
module btms_result_queue
    import btms_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  btms_push_t push,
    output logic       room,
    output logic       res_valid,
    input  logic       res_stall,
    output btms_res_t  head
);

    btms_res_t            q_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_BITS-1:0] count_reg, count_next;
    logic [QPTR_BITS-1:0] wr_ptr_inc;
    logic                 pop;

    assign res_valid  = (count_reg != '0);
    assign pop        = res_valid && !res_stall;
    assign head       = q_reg[rd_ptr_reg];
    // room for the two rows a tick may bring
    assign room       = (count_reg <= QCNT_BITS'(QUEUE_DEPTH - 2));
    assign wr_ptr_inc = wr_ptr_reg + QPTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push.push0)
        begin
            wr_ptr_next = push.push1 ? (wr_ptr_reg + QPTR_BITS'(2)) : wr_ptr_inc;
            count_next  = count_next + (push.push1 ? QCNT_BITS'(2) : QCNT_BITS'(1));
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_BITS'(1);
            count_next  = count_next - QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.push0)
        begin
            q_reg[wr_ptr_reg] <= push.row0;
        end
        if (push.push1)
        begin
            q_reg[wr_ptr_inc] <= push.row1;
        end
    end

endmodule

// ===== hw/rtl/btms_port_checker.sv =====
// ----------------------------------------------------------------------------
// btms_port_checker
// port-level checks on the result channel of the line stepper
// ----------------------------------------------------------------------------
`include "bresenham_two_motor_stepper_assert.svh"

module btms_port_checker
(
    input logic clk,
    input logic rst_n,
    input logic res_valid,
    input logic res_stall,
    input logic step_pulse,
    input logic motor1_cw,
    input logic motor2_cw,
    input logic last_of_run,
    input logic move_done,
    input logic rejected
);

    logic [5:0] row_bits;

    assign row_bits = {step_pulse, motor1_cw, motor2_cw, last_of_run, move_done, rejected};

    // a stalled row stays offered and unchanged
    `BTMS_ASSERT_NEXT(a_stall_hold, res_valid && res_stall, res_valid && $stable(row_bits))

    // status rows carry no motor direction
    `BTMS_ASSERT_NOW(a_idle_dirs, res_valid && !step_pulse, !motor1_cw && !motor2_cw)

    // a finished line or a rejected move closes the request
    `BTMS_ASSERT_NOW(a_flags_last, res_valid && (move_done || rejected), last_of_run)

    // a rejected move neither steps nor completes a line
    `BTMS_ASSERT_NOW(a_reject_clean, res_valid && rejected, !step_pulse && !move_done)

endmodule

bind bresenham_two_motor_stepper btms_port_checker u_port_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the two-motor line stepper against a cycle-free line predictor.
// Move requests and step ticks go in on the cmd channel. Each accepted
// request is run through the predictor, and the step and status rows it
// should give are queued. A checker compares every row on the res channel
// with the oldest queued row. cmd idles and res stalls at random.
// ----------------------------------------------------------------------------
module tb;
    import btms_pkg::*;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [SPU_BITS-1:0]  cfg_wr_data = '0;
    logic                 cmd_valid = 1'b0;
    logic                 cmd_stall;
    logic                 func = FUNC_TICK;
    logic signed [13:0]   target_x = '0;
    logic signed [13:0]   target_y = '0;
    logic                 res_valid;
    logic                 res_stall = 1'b0;
    logic                 step_pulse;
    logic                 motor1_cw;
    logic                 motor2_cw;
    logic                 last_of_run;
    logic                 move_done;
    logic                 rejected;

    // line predictor state
    logic [SPU_BITS-1:0]        scale;
    logic signed [POS_BITS-1:0] pen_x;
    logic signed [POS_BITS-1:0] pen_y;
    longint                     err_acc;
    longint                     minor_inc;
    longint                     major_twice;
    longint                     ticks_left;
    bit                         x_neg;
    bit                         y_neg;
    bit                         y_is_major;
    bit                         line_busy;

    btms_res_t step_rows_q[$];
    int        n_errors = 0;
    int        send_gap_pct = 0;
    int        recv_stall_pct = 0;

    bresenham_two_motor_stepper dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .func        (func),
        .target_x    (target_x),
        .target_y    (target_y),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .step_pulse  (step_pulse),
        .motor1_cw   (motor1_cw),
        .motor2_cw   (motor2_cw),
        .last_of_run (last_of_run),
        .move_done   (move_done),
        .rejected    (rejected)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // one step on an axis: moves the pen and gives the motor directions
    task automatic step_pen(input bit on_y, output btms_res_t row);
        row            = '0;
        row.step_pulse = 1'b1;
        if (on_y)
        begin
            pen_y         = POS_BITS'(y_neg ? pen_y - 1 : pen_y + 1);
            row.motor1_cw = y_neg;
            row.motor2_cw = !y_neg;
        end
        else
        begin
            pen_x         = POS_BITS'(x_neg ? pen_x - 1 : pen_x + 1);
            row.motor1_cw = !x_neg;
            row.motor2_cw = !x_neg;
        end
    endtask

    task automatic predict_rows(input logic f, input logic signed [13:0] x,
                                input logic signed [13:0] y);
        logic signed [POS_BITS-1:0] goal_x;
        logic signed [POS_BITS-1:0] goal_y;
        longint                     dx, dy, ax, ay, span_long, span_short;
        btms_res_t                  row0, row1;
        row0 = '0;
        row1 = '0;
        if (f == FUNC_MOVE)
        begin
            if (line_busy)
            begin
                row0.last_of_run = 1'b1;
                row0.rejected    = 1'b1;
                step_rows_q.push_back(row0);
                return;
            end
            // scaled target wraps to the position width
            goal_x = POS_BITS'(longint'(x) * longint'(scale));
            goal_y = POS_BITS'(longint'(y) * longint'(scale));
            dx = longint'(goal_x) - longint'(pen_x);
            dy = longint'(goal_y) - longint'(pen_y);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            span_long  = ax >= ay ? ax : ay;
            span_short = ax >= ay ? ay : ax;
            if (span_long == 0)
            begin
                row0.last_of_run = 1'b1;
                row0.move_done   = 1'b1;
                step_rows_q.push_back(row0);
                return;
            end
            x_neg       = dx < 0;
            y_neg       = dy < 0;
            y_is_major  = ax < ay;
            err_acc     = -span_long;
            major_twice = 2 * span_long;
            minor_inc   = 2 * span_short;
            ticks_left  = span_long;
            line_busy   = 1'b1;
        end
        else if (line_busy)
        begin
            step_pen(y_is_major, row0);
            err_acc += minor_inc;
            if (err_acc > 0)
            begin
                err_acc -= major_twice;
                step_pen(!y_is_major, row1);
            end
            ticks_left -= 1;
            if (row1.step_pulse)
            begin
                row1.last_of_run = 1'b1;
                row1.move_done   = (ticks_left == 0);
            end
            else
            begin
                row0.last_of_run = 1'b1;
                row0.move_done   = (ticks_left == 0);
            end
            if (ticks_left == 0)
                line_busy = 1'b0;
            step_rows_q.push_back(row0);
            if (row1.step_pulse)
                step_rows_q.push_back(row1);
        end
    endtask

    // drives one request and waits for it to be taken
    task automatic send_req(input logic f, input logic signed [13:0] x,
                            input logic signed [13:0] y);
        if ($urandom_range(0, 99) < send_gap_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_gap_pct);
        end
        cmd_valid <= 1'b1;
        func      <= f;
        target_x  <= x;
        target_y  <= y;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        predict_rows(f, x, y);
    endtask

    task automatic finish_line();
        while (line_busy)
            send_req(FUNC_TICK, 14'($urandom), 14'($urandom));
    endtask

    // lets every expected row out, then the pipeline latency
    task automatic wait_idle();
        cmd_valid <= 1'b0;
        while (step_rows_q.size() != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_steps(input logic [SPU_BITS-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        scale = value;
        cfg_wr_en <= 1'b0;
    endtask

    task automatic check_bit(input string name, input logic want, input logic got);
        if (got !== want)
        begin
            $error("%s: expected %0b, got %0b", name, want, got);
            n_errors++;
        end
    endtask

    always @(posedge clk)
    begin : res_check
        btms_res_t want;
        if (rst_n && res_valid === 1'b1 && res_stall === 1'b0)
        begin
            if (step_rows_q.size() == 0)
            begin
                $error("result row with nothing expected");
                n_errors++;
            end
            else
            begin
                want = step_rows_q.pop_front();
                check_bit("step_pulse", want.step_pulse, step_pulse);
                check_bit("motor1_cw", want.motor1_cw, motor1_cw);
                check_bit("motor2_cw", want.motor2_cw, motor2_cw);
                check_bit("last_of_run", want.last_of_run, last_of_run);
                check_bit("move_done", want.move_done, move_done);
                check_bit("rejected", want.rejected, rejected);
            end
        end
    end

    // small lines at the reset scale of 2: right, up, diagonal and y-major
    task automatic test_directed_lines();
        send_req(FUNC_TICK, 14'sd5, -14'sd5);   // tick while idle
        send_req(FUNC_MOVE, 14'sd0, 14'sd0);    // zero length
        send_req(FUNC_MOVE, 14'sd1, 14'sd0);    // right
        send_req(FUNC_MOVE, -14'sd3, 14'sd2);   // move while busy
        finish_line();
        send_req(FUNC_MOVE, 14'sd1, 14'sd1);    // up
        finish_line();
        send_req(FUNC_MOVE, 14'sd0, 14'sd0);    // diagonal tie, left and down
        finish_line();
        send_req(FUNC_MOVE, -14'sd1, 14'sd2);   // y major with minor steps
        finish_line();
        send_req(FUNC_TICK, -14'sd8192, 14'sd8191);
    endtask

    // scale of zero pulls every target to the origin, extreme targets too
    task automatic test_zero_scale();
        write_steps(4'd0);
        send_req(FUNC_MOVE, 14'sd8191, -14'sd8192);
        finish_line();
        send_req(FUNC_MOVE, -14'sd8192, 14'sd8191);
    endtask

    // mostly complete short lines, with rejected moves and idle ticks mixed in
    task automatic test_random_moves(input int n_items);
        int                 sent;
        int                 pick;
        int                 bx, by, d;
        logic signed [13:0] tx, ty;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (line_busy)
            begin
                if (pick < 6)
                    send_req(FUNC_MOVE, 14'($urandom), 14'($urandom));
                else
                    send_req(FUNC_TICK, 14'($urandom), 14'($urandom));
                sent++;
            end
            else if (pick < 5)
            begin
                send_req(FUNC_TICK, 14'($urandom), 14'($urandom));
            end
            else
            begin
                if (scale == 0)
                begin
                    tx = 14'($urandom);
                    ty = 14'($urandom);
                end
                else
                begin
                    bx = int'(pen_x) / int'(scale);
                    by = int'(pen_y) / int'(scale);
                    if (pick >= 12)
                    begin
                        d  = $urandom_range(0, 8);
                        bx = bx + d - 4;
                        d  = $urandom_range(0, 8);
                        by = by + d - 4;
                    end
                    if (bx > 8191) bx = 8191;
                    if (bx < -8192) bx = -8192;
                    if (by > 8191) by = 8191;
                    if (by < -8192) by = -8192;
                    tx = 14'(bx);
                    ty = 14'(by);
                end
                send_req(FUNC_MOVE, tx, ty);
                sent++;
            end
        end
        finish_line();
    endtask

    initial
    begin
        scale      = SPU_RESET;
        pen_x      = '0;
        pen_y      = '0;
        err_acc    = 0;
        minor_inc  = 0;
        major_twice = 0;
        ticks_left = 0;
        x_neg      = 1'b0;
        y_neg      = 1'b0;
        y_is_major = 1'b0;
        line_busy  = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct   = 25;
        recv_stall_pct = 53;
        test_directed_lines();
        test_zero_scale();
        write_steps(4'd15);
        test_random_moves(300);

        send_gap_pct   = 53;
        recv_stall_pct = 25;
        write_steps(4'd1);
        test_random_moves(300);
        write_steps(4'd0);
        test_random_moves(60);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        write_steps(SPU_BITS'($urandom_range(3, 14)));
        test_random_moves(420);

        wait_idle();
        repeat (10)
            @(posedge clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
